>>> hw/rtl/prt_pkg.sv
// Shared types and constants of the pheromone roulette table.
`default_nettype none

package prt_pkg;

    // Field widths of the channels.
    localparam int W_W         = 24;   // Q8.16 weight
    localparam int RATE_W      = 18;   // Q2.16 rate
    localparam int FRAC_W      = 16;   // Q0.16 random fraction
    localparam int RATE_FRAC_W = 16;   // fraction bits of a rate, so 1.0 is 1 << 16
    localparam int NODE_IN_W   = 6;
    localparam int SLOT_IN_W   = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 24;

    localparam logic [RATE_W-1:0] RATE_ONE = RATE_W'(1) << RATE_FRAC_W;
    localparam logic [W_W-1:0]    W_MAX    = {W_W{1'b1}};

    typedef enum logic [1:0] {
        OP_SELECT    = 2'd0,
        OP_REINFORCE = 2'd1,
        OP_DECAY     = 2'd2,
        OP_LOAD      = 2'd3
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PLACEMENT = 2'd0,
        CFG_DECAY     = 2'd1,
        CFG_MAX_LEVEL = 2'd2,
        CFG_MIN_LEVEL = 2'd3
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SUM,
        ST_SCALE,
        ST_WALK,
        ST_READ,
        ST_MULT,
        ST_WRITE,
        ST_DONE
    } t_state;

    typedef struct packed {
        t_op                  operation;
        logic [NODE_IN_W-1:0] source_node;
        logic [SLOT_IN_W-1:0] slot;
        logic [FRAC_W-1:0]    random_fraction;
        logic [W_W-1:0]       load_value;
    } t_in_item;

    typedef struct packed {
        logic [SLOT_IN_W-1:0] chosen_slot;
        logic [W_W-1:0]       weight_after;
        logic                 select_error;
    } t_out_item;

    typedef struct packed {
        logic [RATE_W-1:0] placement_rate;
        logic [RATE_W-1:0] decay_rate;
        logic [W_W-1:0]    max_level;
        logic [W_W-1:0]    min_level;
    } t_cfg;

    typedef struct packed {
        logic idle;
        logic done;
    } t_eng_status;

endpackage

`default_nettype wire

>>> hw/rtl/prt_cfg_regs.sv
// Configuration register file of the pheromone roulette table.
`default_nettype none

module prt_cfg_regs (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [prt_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [prt_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output prt_pkg::t_cfg                       o_cfg
);
    import prt_pkg::*;

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.placement_rate <= RATE_ONE;
            r_cfg.decay_rate     <= RATE_ONE;
            r_cfg.max_level      <= W_MAX;
            r_cfg.min_level      <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_PLACEMENT: r_cfg.placement_rate <= i_cfg_data[RATE_W-1:0];
                CFG_DECAY:     r_cfg.decay_rate     <= i_cfg_data[RATE_W-1:0];
                CFG_MAX_LEVEL: r_cfg.max_level      <= i_cfg_data[W_W-1:0];
                CFG_MIN_LEVEL: r_cfg.min_level      <= i_cfg_data[W_W-1:0];
                default:       r_cfg                <= r_cfg;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/prt_table_mem.sv
// Weight table memory: one write port, one read port with registered read data.
`default_nettype none

module prt_table_mem #(
    parameter  int DEPTH  = 1024,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_we,
    input  wire logic [ADDR_W-1:0]         i_waddr,
    input  wire logic [prt_pkg::W_W-1:0]   i_wdata,
    input  wire logic                      i_re,
    input  wire logic [ADDR_W-1:0]         i_raddr,
    output logic      [prt_pkg::W_W-1:0]   o_rdata
);
    import prt_pkg::*;

    logic [W_W-1:0] r_mem [DEPTH];
    logic [W_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> hw/rtl/prt_engine.sv
// Sequencer and datapath: clearing pass, roulette select and read-modify-write updates.
`default_nettype none

module prt_engine #(
    parameter  int NODE_COUNT = 64,
    parameter  int SLOT_COUNT = 16,
    localparam int ADDR_W     = $clog2(NODE_COUNT * SLOT_COUNT)
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_in_valid,
    input  prt_pkg::t_in_item            i_in_data,
    input  prt_pkg::t_cfg                i_cfg,
    input  wire logic                    i_out_free,
    output prt_pkg::t_eng_status         o_status,
    output prt_pkg::t_out_item           o_res,
    output logic                         o_mem_we,
    output logic [ADDR_W-1:0]            o_mem_waddr,
    output logic [prt_pkg::W_W-1:0]      o_mem_wdata,
    output logic                         o_mem_re,
    output logic [ADDR_W-1:0]            o_mem_raddr,
    input  wire logic [prt_pkg::W_W-1:0] i_mem_rdata
);
    import prt_pkg::*;

    localparam int DEPTH  = NODE_COUNT * SLOT_COUNT;
    localparam int ROW_W  = $clog2(NODE_COUNT);
    localparam int SLOT_W = $clog2(SLOT_COUNT);
    localparam int CNT_W  = SLOT_W + 1;
    localparam int TOT_W  = W_W + SLOT_W;
    localparam int SEL_W  = FRAC_W + TOT_W;
    localparam int PROD_W = W_W + RATE_W;
    localparam int SC_W   = PROD_W - RATE_FRAC_W;
    localparam int RED_W  = NODE_IN_W + ROW_W + 1;
    localparam int CMP_W  = ((SLOT_IN_W > CNT_W) ? SLOT_IN_W : CNT_W) + 1;

    // Wraps the row index modulo NODE_COUNT by restoring subtraction.
    function automatic logic [ROW_W-1:0] wrap_row(input logic [NODE_IN_W-1:0] node);
        logic [RED_W-1:0] v;
        v = RED_W'(node);
        for (int k = NODE_IN_W - 1; k >= 0; k--) begin
            if (v >= (RED_W'(NODE_COUNT) << k)) begin
                v = v - (RED_W'(NODE_COUNT) << k);
            end
        end
        return v[ROW_W-1:0];
    endfunction

    t_state              r_state, n_state;
    logic [ADDR_W-1:0]   r_clr, n_clr;
    t_in_item            r_in, n_in;
    logic [ADDR_W-1:0]   r_base, n_base;
    logic [CNT_W-1:0]    r_idx, n_idx;
    logic                r_pend, n_pend;
    logic [SLOT_W-1:0]   r_pend_idx, n_pend_idx;
    logic [TOT_W-1:0]    r_total, n_total;
    logic [TOT_W-1:0]    r_rem, n_rem;
    logic [PROD_W-1:0]   r_prod, n_prod;
    t_out_item           r_res, n_res;

    logic                pend_last;
    logic                issue_ok;
    logic                slot_ok;
    logic [TOT_W-1:0]    rd_ext;
    logic [SEL_W-1:0]    sel_prod;
    logic [SC_W-1:0]     scaled;
    logic [W_W-1:0]      sat_w;
    logic [W_W-1:0]      upd_w;
    logic [RATE_W-1:0]   rate;
    logic [ADDR_W-1:0]   slot_addr;

    assign pend_last = (r_pend_idx == SLOT_W'(SLOT_COUNT - 1));
    assign issue_ok  = (r_idx < CNT_W'(SLOT_COUNT));
    assign slot_ok   = (CMP_W'(r_in.slot) < CMP_W'(SLOT_COUNT));
    assign rd_ext    = TOT_W'(i_mem_rdata);
    assign sel_prod  = SEL_W'(r_in.random_fraction) * SEL_W'(r_total);
    assign scaled    = r_prod[PROD_W-1:RATE_FRAC_W];
    assign sat_w     = (|scaled[SC_W-1:W_W]) ? W_MAX : scaled[W_W-1:0];
    assign rate      = (r_in.operation == OP_REINFORCE) ? i_cfg.placement_rate
                                                        : i_cfg.decay_rate;
    assign slot_addr = r_base + ADDR_W'(r_in.slot);

    always_comb begin
        unique case (r_in.operation)
            OP_REINFORCE: upd_w = (sat_w > i_cfg.max_level) ? i_cfg.max_level : sat_w;
            OP_DECAY:     upd_w = (sat_w < i_cfg.min_level) ? i_cfg.min_level : sat_w;
            OP_LOAD:      upd_w = r_in.load_value;
            default:      upd_w = sat_w;
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_in        = r_in;
        n_base      = r_base;
        n_idx       = r_idx;
        n_pend      = 1'b0;
        n_pend_idx  = r_idx[SLOT_W-1:0];
        n_total     = r_total;
        n_rem       = r_rem;
        n_prod      = r_prod;
        n_res       = r_res;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_clr;
        o_mem_wdata = '0;
        o_mem_re    = 1'b0;
        o_mem_raddr = r_base + ADDR_W'(r_idx[SLOT_W-1:0]);

        unique case (r_state)
            ST_CLEAR: begin
                o_mem_we = 1'b1;
                n_clr    = r_clr + ADDR_W'(1);
                if (r_clr == ADDR_W'(DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_in    = i_in_data;
                    n_base  = ADDR_W'(wrap_row(i_in_data.source_node)) * ADDR_W'(SLOT_COUNT);
                    n_idx   = '0;
                    n_total = '0;
                    n_state = (i_in_data.operation == OP_SELECT) ? ST_SUM : ST_READ;
                end
            end
            ST_SUM: begin
                if (issue_ok) begin
                    o_mem_re = 1'b1;
                    n_pend   = 1'b1;
                    n_idx    = r_idx + CNT_W'(1);
                end
                if (r_pend) begin
                    n_total = r_total + rd_ext;
                    if (pend_last) begin
                        n_state = ST_SCALE;
                    end
                end
            end
            ST_SCALE: begin
                if (r_total == '0) begin
                    n_res.chosen_slot  = '0;
                    n_res.weight_after = '0;
                    n_res.select_error = 1'b1;
                    n_state            = ST_DONE;
                end else begin
                    n_rem   = sel_prod[SEL_W-1:FRAC_W];
                    n_idx   = '0;
                    n_state = ST_WALK;
                end
            end
            ST_WALK: begin
                if (issue_ok) begin
                    o_mem_re = 1'b1;
                    n_pend   = 1'b1;
                    n_idx    = r_idx + CNT_W'(1);
                end
                if (r_pend) begin
                    if (r_rem < rd_ext) begin
                        n_res.chosen_slot  = SLOT_IN_W'(r_pend_idx);
                        n_res.weight_after = i_mem_rdata;
                        n_res.select_error = 1'b0;
                        n_state            = ST_DONE;
                    end else begin
                        n_rem = r_rem - rd_ext;
                        if (pend_last) begin
                            n_res.chosen_slot  = '0;
                            n_res.weight_after = '0;
                            n_res.select_error = 1'b0;
                            n_state            = ST_DONE;
                        end
                    end
                end
            end
            ST_READ: begin
                if (slot_ok) begin
                    o_mem_re    = 1'b1;
                    o_mem_raddr = slot_addr;
                    n_state     = ST_MULT;
                end else begin
                    n_res.chosen_slot  = r_in.slot;
                    n_res.weight_after = '0;
                    n_res.select_error = 1'b0;
                    n_state            = ST_DONE;
                end
            end
            ST_MULT: begin
                n_prod  = PROD_W'(i_mem_rdata) * PROD_W'(rate);
                n_state = ST_WRITE;
            end
            ST_WRITE: begin
                o_mem_we           = 1'b1;
                o_mem_waddr        = slot_addr;
                o_mem_wdata        = upd_w;
                n_res.chosen_slot  = r_in.slot;
                n_res.weight_after = upd_w;
                n_res.select_error = 1'b0;
                n_state            = ST_DONE;
            end
            ST_DONE: begin
                if (i_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in       <= n_in;
        r_base     <= n_base;
        r_idx      <= n_idx;
        r_pend_idx <= n_pend_idx;
        r_total    <= n_total;
        r_rem      <= n_rem;
        r_prod     <= n_prod;
        r_res      <= n_res;
    end

    assign o_status.idle = (r_state == ST_IDLE);
    assign o_status.done = (r_state == ST_DONE);
    assign o_res         = r_res;

endmodule

`default_nettype wire

>>> hw/rtl/pheromone_roulette_table_core.sv
// Top level of the pheromone roulette table: config registers, engine, table and output register.
//
// Usage. Items arrive on the input channel (i_in_valid, o_in_stall, i_in_data) and each
// produces exactly one result beat on the output channel (o_out_valid, i_out_stall,
// o_out_data). A beat moves at a rising edge where valid is high and stall is low.
// Configuration writes use i_cfg_valid / o_cfg_ready with a register index and data;
// the port is always ready, and writes are meant to happen while the block is idle.
//
// Timing. The block works on one item at a time and the table memory port sets the pace.
// A select reads the row once to sum it and, unless the total is zero, a second time to walk it
// up to the chosen slot. Reinforce, decay and load are one read-modify-write each.
//
// Reset. After reset the block clears the table one entry per cycle, all NODE_COUNT*SLOT_COUNT
// entries (1024 by default); o_in_stall stays high meanwhile.
//
// Stalls. A finished result sits in the output register. The next item is accepted while
// it waits; a second result waits inside the engine until the output register frees up.
`default_nettype none

module pheromone_roulette_table_core #(
    parameter int NODE_COUNT = 64,
    parameter int SLOT_COUNT = 16
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  prt_pkg::t_in_item                   i_in_data,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output prt_pkg::t_out_item                  o_out_data,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [prt_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [prt_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import prt_pkg::*;

    localparam int DEPTH  = NODE_COUNT * SLOT_COUNT;
    localparam int ADDR_W = $clog2(DEPTH);

    t_cfg              cfg;
    t_eng_status       status;
    t_out_item         res;
    logic              out_free;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [W_W-1:0]    mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;
    logic [W_W-1:0]    mem_rdata;

    logic              r_out_vld, n_out_vld;
    t_out_item         r_out, n_out;

    prt_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    prt_table_mem #(
        .DEPTH (DEPTH)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    prt_engine #(
        .NODE_COUNT (NODE_COUNT),
        .SLOT_COUNT (SLOT_COUNT)
    ) u_eng (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .i_cfg       (cfg),
        .i_out_free  (out_free),
        .o_status    (status),
        .o_res       (res),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_re    (mem_re),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    // The output register can take a new result when it is empty or its beat moves now.
    assign out_free = !r_out_vld || !i_out_stall;

    always_comb begin
        n_out_vld = r_out_vld;
        n_out     = r_out;
        if (out_free) begin
            n_out_vld = status.done;
            if (status.done) begin
                n_out = res;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    // Only an idle engine takes an item; the clearing pass keeps it busy after reset.
    assign o_in_stall  = !status.idle;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

>>> hw/rtl/prt_checker.sv
// Port-level assertions for the pheromone roulette table and their bind to the top level.
`default_nettype none

module prt_checker (
    input wire logic         i_clk,
    input wire logic         i_rst_n,
    input wire logic         i_in_valid,
    input wire logic         o_in_stall,
    input wire logic         o_out_valid,
    input wire logic         i_out_stall,
    input prt_pkg::t_out_item o_out_data
);
    import prt_pkg::*;

    // A stalled result beat keeps its contents.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result beat changed while stalled");

    // One item at a time: after an accept the block is busy.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input accepted on consecutive cycles");

    // Reset starts the clearing pass, so no item is taken right after it.
    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall)
        else $error("input not stalled after reset");

    // A zero row total reports slot zero with weight zero.
    a_error_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.select_error |->
            (o_out_data.chosen_slot == '0) && (o_out_data.weight_after == '0))
        else $error("select error with non-zero slot or weight");

endmodule

bind pheromone_roulette_table_core prt_checker u_prt_checker (.*);

`default_nettype wire

>>> dv/tb_pheromone_roulette_table_core.sv
// Self-checking testbench for the pheromone roulette table: directed table plus random phases.
`default_nettype none

module tb_pheromone_roulette_table_core;
    timeunit 1ns;
    timeprecision 1ps;

    import prt_pkg::*;

    localparam int NODES           = 64;
    localparam int SLOTS           = 16;
    localparam int PHASES          = 7;
    localparam int ITEMS_PER_PHASE = 100;
    // Long enough for the slowest select, a walk over a full row, so this covers any beat still in flight.
    localparam int SETTLE_CYCLES   = 48;
    localparam int REPORT_LIMIT    = 10;

    // Sender idle and receiver stall odds, in percent per cycle, for each phase.
    localparam int IDLE_BY_PHASE [PHASES]  = '{0, 82, 0, 22, 0, 82, 0};
    localparam int STALL_BY_PHASE [PHASES] = '{0, 0, 82, 22, 0, 0, 82};

    typedef struct {
        t_in_item  item;
        bit        typed;
        t_out_item result;
    } t_stim_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    t_in_item              i_in_data = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_out_item             o_out_data;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // Predicted copy of the weight table and of the four registers.
    logic [W_W-1:0]    pheromone [NODES*SLOTS];
    logic [RATE_W-1:0] cfg_place = RATE_ONE;
    logic [RATE_W-1:0] cfg_decay = RATE_ONE;
    logic [W_W-1:0]    cfg_max = W_MAX;
    logic [W_W-1:0]    cfg_min = '0;

    t_out_item         pending_results [$];
    t_stim_row         stim_table [$];
    logic [NODE_IN_W-1:0] busy_rows [4];

    int idle_pct = 0;
    int stall_pct = 0;
    int fail_count = 0;
    int n_items = 0;
    int n_results = 0;
    int n_empty_rows = 0;

    pheromone_roulette_table_core #(
        .NODE_COUNT(NODES),
        .SLOT_COUNT(SLOTS)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: far beyond the slowest legal run, including the clearing pass after reset.
    initial begin
        #3_000_000;
        $display("timeout with %0d result beats still outstanding", pending_results.size());
        $display("tb_pheromone_roulette_table_core failed");
        $finish;
    end

    initial begin
        for (int k = 0; k < NODES*SLOTS; k++) begin
            pheromone[k] = '0;
        end
    end

    function automatic logic [W_W-1:0] scale_by_rate(input logic [W_W-1:0] w,
                                                     input logic [RATE_W-1:0] rate);
        logic [W_W+RATE_W-1:0] prod;
        prod = (W_W+RATE_W)'(w) * (W_W+RATE_W)'(rate);
        prod = prod >> RATE_FRAC_W;
        return (prod > (W_W+RATE_W)'(W_MAX)) ? W_MAX : prod[W_W-1:0];
    endfunction

    // Applies one operation to the predicted table and returns the beat it should produce.
    function automatic t_out_item apply_pheromone_op(input t_in_item it);
        t_out_item      r;
        int             base;
        int             i;
        logic [31:0]    total;
        logic [47:0]    remainder;
        logic [W_W-1:0] w;
        bit             found;
        r = '0;
        r.chosen_slot = it.slot;
        base = int'(it.source_node) * SLOTS;
        if (it.operation == OP_SELECT) begin
            r.chosen_slot = '0;
            total = '0;
            for (i = 0; i < SLOTS; i++) begin
                total += 32'(pheromone[base+i]);
            end
            if (total == 0) begin
                r.select_error = 1'b1;
            end else begin
                // Scale the fraction by the row total, then walk the slots in order.
                remainder = (48'(it.random_fraction) * 48'(total)) >> FRAC_W;
                found = 1'b0;
                for (i = 0; i < SLOTS; i++) begin
                    if (!found) begin
                        if (remainder < 48'(pheromone[base+i])) begin
                            found = 1'b1;
                            r.chosen_slot = SLOT_IN_W'(i);
                            r.weight_after = pheromone[base+i];
                        end else begin
                            remainder -= 48'(pheromone[base+i]);
                        end
                    end
                end
            end
        end else begin
            w = pheromone[base+int'(it.slot)];
            case (it.operation)
                OP_REINFORCE: begin
                    w = scale_by_rate(w, cfg_place);
                    if (w > cfg_max) w = cfg_max;
                end
                OP_DECAY: begin
                    w = scale_by_rate(w, cfg_decay);
                    if (w < cfg_min) w = cfg_min;
                end
                default: w = it.load_value;
            endcase
            pheromone[base+int'(it.slot)] = w;
            r.weight_after = w;
        end
        return r;
    endfunction

    function automatic t_out_item out_beat(input int slot, input int weight, input bit err);
        return t_out_item'({SLOT_IN_W'(slot), W_W'(weight), err});
    endfunction

    function automatic t_stim_row stim_row(input t_op op, input int node, input int slot,
                                           input int frac, input int load,
                                           input bit typed, input t_out_item res);
        t_stim_row s;
        s.item.operation = op;
        s.item.source_node = NODE_IN_W'(node);
        s.item.slot = SLOT_IN_W'(slot);
        s.item.random_fraction = FRAC_W'(frac);
        s.item.load_value = W_W'(load);
        s.typed = typed;
        s.result = res;
        return s;
    endfunction

    // Appends one row to the directed table.
    function automatic void add_row(input t_stim_row s);
        stim_table.insert(stim_table.size(), s);
    endfunction

    // Random items mostly land on a few busy rows so that selects walk populated rows.
    function automatic t_in_item random_item();
        t_in_item it;
        int       pick;
        pick = $urandom_range(99);
        if (pick < 35)      it.operation = OP_SELECT;
        else if (pick < 50) it.operation = OP_REINFORCE;
        else if (pick < 65) it.operation = OP_DECAY;
        else                it.operation = OP_LOAD;
        it.source_node = ($urandom_range(4) == 0) ? NODE_IN_W'($urandom)
                                                  : busy_rows[$urandom_range(3)];
        it.slot = SLOT_IN_W'($urandom);
        case ($urandom_range(9))
            0:       it.random_fraction = '0;
            1:       it.random_fraction = '1;
            default: it.random_fraction = FRAC_W'($urandom);
        endcase
        case ($urandom_range(7))
            0:       it.load_value = '0;
            1:       it.load_value = W_MAX;
            2, 3:    it.load_value = W_W'($urandom_range(1, 4095));
            default: it.load_value = W_W'($urandom);
        endcase
        return it;
    endfunction

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= REPORT_LIMIT) $display("ERROR at %0t: %s", $realtime, msg);
    endtask

    // Writes the four registers back to back; valid stays high across the burst.
    task automatic configure(input logic [23:0] place, input logic [23:0] decay,
                             input logic [23:0] max_lvl, input logic [23:0] min_lvl);
        logic [23:0] vals [4];
        t_cfg_idx    idx;
        int          k;
        vals = '{place, decay, max_lvl, min_lvl};
        for (k = 0; k < 4; k++) begin
            idx = t_cfg_idx'(k);
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx;
            i_cfg_data <= vals[k];
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
            case (idx)
                CFG_PLACEMENT: cfg_place = vals[k][RATE_W-1:0];
                CFG_DECAY:     cfg_decay = vals[k][RATE_W-1:0];
                CFG_MAX_LEVEL: cfg_max = vals[k][W_W-1:0];
                CFG_MIN_LEVEL: cfg_min = vals[k][W_W-1:0];
            endcase
        end
        i_cfg_valid <= 1'b0;
    endtask

    // Offers one beat, waits for it to be taken, then records what it should return.
    task automatic send_item(input t_in_item it, input bit typed, input t_out_item typed_result);
        t_out_item predicted;
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predicted = apply_pheromone_op(it);
        pending_results.insert(pending_results.size(), typed ? typed_result : predicted);
        n_items++;
    endtask

    task automatic wait_for_drain();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic check_beat(input t_out_item got);
        t_out_item want;
        n_results++;
        if (got.select_error) n_empty_rows++;
        if (pending_results.size() == 0) begin
            note_failure($sformatf("result beat %h arrived with nothing outstanding", got));
            return;
        end
        want = pending_results.pop_front();
        if (got.chosen_slot !== want.chosen_slot || got.weight_after !== want.weight_after ||
            got.select_error !== want.select_error) begin
            note_failure($sformatf("slot %0d/%0d weight %h/%h error %0b/%0b (expected/actual)",
                                   want.chosen_slot, got.chosen_slot, want.weight_after,
                                   got.weight_after, want.select_error, got.select_error));
        end
    endtask

    // Output side: check every beat that moves, then pick the stall for the next cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) check_beat(o_out_data);
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    initial begin : stimulus
        int phase;
        int k;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed rows. Typed results are the ones that follow from reset values,
        // extremes and empty rows; the rest come from the predictor.
        add_row(stim_row(OP_SELECT, 0, 0, 0, 0, 1, out_beat(0, 0, 1)));
        add_row(stim_row(OP_SELECT, 63, 15, 'hFFFF, 'hFFFFFF, 1, out_beat(0, 0, 1)));
        add_row(stim_row(OP_LOAD, 0, 0, 0, 'hFFFFFF, 1, out_beat(0, 'hFFFFFF, 0)));
        add_row(stim_row(OP_LOAD, 0, 15, 0, 1, 1, out_beat(15, 1, 0)));
        add_row(stim_row(OP_SELECT, 0, 0, 0, 0, 0, '0));
        add_row(stim_row(OP_SELECT, 0, 0, 'hFFFF, 0, 0, '0));
        add_row(stim_row(OP_LOAD, 63, 15, 'hAAAA, 'h10, 1, out_beat(15, 'h10, 0)));
        add_row(stim_row(OP_SELECT, 63, 9, 'hFFFF, 0, 0, '0));
        add_row(stim_row(OP_SELECT, 63, 0, 0, 0, 0, '0));
        // Unity rates leave the weight as it is.
        add_row(stim_row(OP_REINFORCE, 0, 0, 0, 0, 1, out_beat(0, 'hFFFFFF, 0)));
        add_row(stim_row(OP_DECAY, 0, 15, 0, 0, 1, out_beat(15, 1, 0)));
        add_row(stim_row(OP_LOAD, 21, 7, 0, 0, 1, out_beat(7, 0, 0)));
        add_row(stim_row(OP_REINFORCE, 21, 7, 0, 0, 1, out_beat(7, 0, 0)));
        add_row(stim_row(OP_DECAY, 21, 7, 0, 0, 1, out_beat(7, 0, 0)));
        add_row(stim_row(OP_SELECT, 21, 7, 'h1234, 0, 1, out_beat(0, 0, 1)));
        add_row(stim_row(OP_LOAD, 42, 3, 0, 'h123456, 1, out_beat(3, 'h123456, 0)));
        add_row(stim_row(OP_LOAD, 42, 9, 0, 'h654321, 1, out_beat(9, 'h654321, 0)));
        add_row(stim_row(OP_SELECT, 42, 0, 'h8000, 0, 0, '0));
        add_row(stim_row(OP_SELECT, 42, 0, 'h5555, 0, 0, '0));
        add_row(stim_row(OP_DECAY, 42, 3, 0, 0, 1, out_beat(3, 'h123456, 0)));
        add_row(stim_row(OP_REINFORCE, 42, 9, 0, 0, 1, out_beat(9, 'h654321, 0)));
        // Emptying the row again must bring the error back.
        add_row(stim_row(OP_LOAD, 42, 3, 0, 0, 1, out_beat(3, 0, 0)));
        add_row(stim_row(OP_LOAD, 42, 9, 0, 0, 1, out_beat(9, 0, 0)));
        add_row(stim_row(OP_SELECT, 42, 5, 'hFFFF, 0, 1, out_beat(0, 0, 1)));

        for (phase = 0; phase < PHASES; phase++) begin
            if (phase > 0) wait_for_drain();
            // Register settings per phase; phase 0 runs on the reset values.
            case (phase)
                1: configure(24'h03FFFF, 24'h000000, 24'hFFFFFF, 24'h000000);
                2: configure(24'h018000, 24'h00C000, 24'h800000, 24'h000100);
                // Floor above ceiling: each clamp applies on its own.
                3: configure(24'($urandom_range(0, 262143)), 24'($urandom_range(0, 262143)),
                             24'h001000, 24'h400000);
                4: configure(24'h000000, 24'h03FFFF, 24'h000000, 24'hFFFFFF);
                5: configure(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom));
                6: configure(24'(RATE_ONE), 24'(RATE_ONE), 24'(W_MAX), 24'h000000);
                default: ;
            endcase
            idle_pct = IDLE_BY_PHASE[phase];
            stall_pct = STALL_BY_PHASE[phase];
            for (k = 0; k < 4; k++) begin
                busy_rows[k] = NODE_IN_W'($urandom);
            end
            if (phase == 0) begin
                foreach (stim_table[r]) begin
                    send_item(stim_table[r].item, stim_table[r].typed, stim_table[r].result);
                end
            end
            for (k = 0; k < ITEMS_PER_PHASE; k++) begin
                send_item(random_item(), 1'b0, '0);
            end
            i_in_valid <= 1'b0;
        end

        stall_pct = 0;
        wait_for_drain();
        $display("Ran %0d input beats over %0d register settings with mixed idling and stalls.",
                 n_items, PHASES);
        $display("Checked %0d result beats, %0d of them selects on an empty row; %0d mismatches.",
                 n_results, n_empty_rows, fail_count);
        if (fail_count == 0) begin
            $display("tb_pheromone_roulette_table_core passed");
        end else begin
            $display("tb_pheromone_roulette_table_core failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
